/* src/spl_pkg.sv */
// Shared types, sizes and codes for the sorted priority list.
// Used by spl_cell and by the sorted_priority_list top level.
package spl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int LEVEL_W  = 16;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [LEVEL_W-1:0] level;
  } cell_data_t;

  typedef struct packed {
    cell_op_t   op;
    cell_data_t load_data;
  } cell_cmd_t;

endpackage

/* src/spl_cell.sv */
// One slot of the list: holds an id and a level, compares them with the
// search key and shifts toward either neighbor. Depends on spl_pkg.
module spl_cell import spl_pkg::*; (
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic       occupied,
  input  cell_data_t key,
  input  cell_data_t left_in,
  input  cell_data_t right_in,
  output cell_data_t data_out,
  output logic       match,
  output logic       le_key
);

  cell_data_t data_r;
  cell_data_t data_nxt;

  always_comb begin
    unique case (cmd.op)
      CELL_HOLD:       data_nxt = data_r;
      CELL_TAKE_LEFT:  data_nxt = left_in;
      CELL_TAKE_RIGHT: data_nxt = right_in;
      CELL_LOAD:       data_nxt = cmd.load_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign match    = occupied && (data_r.id == key.id);
  assign le_key   = occupied && ($signed(data_r.level) <= $signed(key.level));

endmodule

/* src/sorted_priority_list.sv */
// Sorted priority list: a chain of CAPACITY cells kept in ascending level order.
// Steps: the compare is registered when an item is accepted and the result is
// registered in the apply step; a level change runs remove, compare again, insert.
// Input: in_tready is high only when idle, so a new item waits until the last one
// has finished its compare-then-shift pass over the cell chain.
// Reset: synchronous active-low rst_n clears the count and control; no clearing pass.
module sorted_priority_list import spl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,  // item_id[15:0], level[31:16], position[37:32]
  input  logic [KIND_W-1:0]   in_tuser,  // kind[1:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata, // entry_id[15:0], entry_level[31:16],
                                         // entry_count[38:32]
  output logic [STATUS_W-1:0] out_tuser  // status[2:0]
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [KIND_W-1:0]   op_kind_r;
  logic [ID_W-1:0]     op_id_r;
  logic [LEVEL_W-1:0]  op_level_r;
  logic [POS_W-1:0]    op_pos_r;
  logic                phase_ins_r;
  logic                found_r;
  logic [IDX_W-1:0]    rm_pos_r;
  logic [IDX_W-1:0]    ins_pos_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic       accept;
  logic       compare_en;
  cell_data_t key;
  cell_data_t load_data;

  cell_data_t         cell_q [CAPACITY];
  cell_cmd_t          cell_cmd [CAPACITY];
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] le_v;
  logic [CAPACITY-1:0] boundary_v;
  logic [CAPACITY-1:0] read_hit_v;

  logic [IDX_W-1:0] rm_pos_c;
  logic [IDX_W-1:0] ins_pos_c;
  cell_data_t       rd_data;

  logic advance;
  logic id_zero;
  logic is_read;
  logic is_full;
  logic read_ok;
  logic do_ins;
  logic do_rm;
  logic to_cmp;
  logic emit;
  logic [STATUS_W-1:0] status_c;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign compare_en = accept || (state_r == ST_CMP);

  always_comb begin
    if (state_r == ST_IDLE) begin
      key.id    = in_tdata[15:0];
      key.level = in_tdata[31:16];
    end else begin
      key.id    = op_id_r;
      key.level = op_level_r;
    end
  end

  assign load_data.id    = op_id_r;
  assign load_data.level = op_level_r;

  assign id_zero = (op_id_r == '0);
  assign is_read = (op_kind_r == KIND_READ);
  assign is_full = (count_r == CNT_W'(CAPACITY));
  assign read_ok = (32'(op_pos_r) < 32'(count_r));
  assign advance = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
  assign do_ins  = advance && !is_read && !id_zero && phase_ins_r && !found_r && !is_full;
  assign do_rm   = advance && !is_read && !id_zero && !phase_ins_r && found_r;
  assign to_cmp  = do_rm && (op_kind_r == KIND_CHANGE);
  assign emit    = advance && !to_cmp;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_data_t left_d;
      cell_data_t right_d;

      if (gi == 0) begin : g_first
        assign left_d = cell_q[gi];
      end else begin : g_left
        assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_q[gi];
      end else begin : g_right
        assign right_d = cell_q[gi+1];
      end

      if (gi == 0) begin : g_bnd_first
        assign boundary_v[gi] = !le_v[gi];
      end else begin : g_bnd
        assign boundary_v[gi] = !le_v[gi] && le_v[gi-1];
      end

      assign read_hit_v[gi] = (32'(op_pos_r) == 32'(gi));

      always_comb begin
        cell_cmd[gi].load_data = load_data;
        priority if (do_ins && (IDX_W'(gi) == ins_pos_r)) begin
          cell_cmd[gi].op = CELL_LOAD;
        end else if (do_ins && (IDX_W'(gi) > ins_pos_r)) begin
          cell_cmd[gi].op = CELL_TAKE_LEFT;
        end else if (do_rm && (IDX_W'(gi) >= rm_pos_r)) begin
          cell_cmd[gi].op = CELL_TAKE_RIGHT;
        end else begin
          cell_cmd[gi].op = CELL_HOLD;
        end
      end

      spl_cell u_cell (
        .clk      (clk),
        .cmd      (cell_cmd[gi]),
        .occupied (32'(count_r) > 32'(gi)),
        .key      (key),
        .left_in  (left_d),
        .right_in (right_d),
        .data_out (cell_q[gi]),
        .match    (match_v[gi]),
        .le_key   (le_v[gi])
      );
    end
  endgenerate

  always_comb begin
    rm_pos_c  = '0;
    ins_pos_c = '0;
    rd_data   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_v[i]) begin
        rm_pos_c = rm_pos_c | IDX_W'(i);
      end
      if (boundary_v[i]) begin
        ins_pos_c = ins_pos_c | IDX_W'(i);
      end
      if (read_hit_v[i]) begin
        rd_data = rd_data | cell_q[i];
      end
    end
  end

  always_comb begin
    priority if (is_read) begin
      status_c = read_ok ? ST_OK : ST_INVALID;
    end else if (id_zero) begin
      status_c = ST_INVALID;
    end else if (!phase_ins_r && !found_r) begin
      status_c = ST_NOT_FOUND;
    end else if (phase_ins_r && found_r) begin
      status_c = ST_DUPLICATE;
    end else if (phase_ins_r && is_full) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: if (advance) state_nxt = to_cmp ? ST_CMP : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_ins) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rm) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind_r  <= in_tuser;
      op_id_r    <= in_tdata[15:0];
      op_level_r <= in_tdata[31:16];
      op_pos_r   <= in_tdata[37:32];
    end
    if (compare_en) begin
      phase_ins_r <= accept ? (in_tuser == KIND_INSERT) : 1'b1;
      found_r     <= |match_v;
      rm_pos_r    <= rm_pos_c;
      ins_pos_r   <= ins_pos_c;
    end
    if (emit) begin
      out_status_r <= status_c;
      out_id_r     <= (is_read && read_ok) ? rd_data.id : '0;
      out_level_r  <= (is_read && read_ok) ? rd_data.level : '0;
      if (do_ins) begin
        out_count_r <= COUNT_W'(count_r + CNT_W'(1));
      end else if (do_rm) begin
        out_count_r <= COUNT_W'(count_r - CNT_W'(1));
      end else begin
        out_count_r <= COUNT_W'(count_r);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_level_r, out_id_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPLY) |=> (count_r == $past(count_r)))
    else $error("entry count changed outside the apply step");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |=> (count_r == $past(count_r)) ||
      (count_r == $past(count_r) + CNT_W'(1)) || (count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == COUNT_W'(CAPACITY)))
    else $error("full status reported on a list that is not full");
`endif

endmodule

/* bench/tb_sorted_priority_list.sv */
`timescale 1ns / 100ps
// Testbench for sorted_priority_list: drives insert, remove, change and read items
// through the input stream and checks every result item against a local list model.
// Depends on spl_pkg and the sorted_priority_list RTL.
module tb_sorted_priority_list;
  import spl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [ID_W-1:0]           entry_id;
    logic signed [LEVEL_W-1:0] entry_level;
    logic [COUNT_W-1:0]        entry_count;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [39:0]         in_tdata;  // item_id[15:0], level[31:16], position[37:32]
  logic [KIND_W-1:0]   in_tuser;  // kind[1:0]
  logic                out_tvalid;
  logic                out_tready;
  logic [39:0]         out_tdata; // entry_id[15:0], entry_level[31:16], entry_count[38:32]
  logic [STATUS_W-1:0] out_tuser; // status[2:0]

  logic [ID_W-1:0]           list_ids [CAPACITY];
  logic signed [LEVEL_W-1:0] list_levels [CAPACITY];
  int                        list_count;
  list_result_t              pending_results[$];
  int                        mismatch_count;
  bit                        calm;

  sorted_priority_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < list_count; i++) begin
      if (list_ids[i] == id) return i;
    end
    return list_count;
  endfunction

  function automatic logic [STATUS_W-1:0] list_insert(logic [ID_W-1:0] id,
                                                     logic signed [LEVEL_W-1:0] lvl);
    int pos;
    if (id == '0) return ST_INVALID;
    if (find_slot(id) < list_count) return ST_DUPLICATE;
    if (list_count >= CAPACITY) return ST_FULL;
    pos = 0;
    while (pos < list_count && list_levels[pos] <= lvl) pos++;
    for (int i = list_count; i > pos; i--) begin
      list_ids[i]    = list_ids[i-1];
      list_levels[i] = list_levels[i-1];
    end
    list_ids[pos]    = id;
    list_levels[pos] = lvl;
    list_count++;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] list_remove(logic [ID_W-1:0] id);
    int idx;
    if (id == '0) return ST_INVALID;
    idx = find_slot(id);
    if (idx >= list_count) return ST_NOT_FOUND;
    for (int i = idx; i + 1 < list_count; i++) begin
      list_ids[i]    = list_ids[i+1];
      list_levels[i] = list_levels[i+1];
    end
    list_count--;
    return ST_OK;
  endfunction

  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [ID_W-1:0] id,
                                                 logic signed [LEVEL_W-1:0] lvl,
                                                 logic [POS_W-1:0] pos);
    list_result_t res;
    res = '0;
    case (kind)
      KIND_INSERT: res.status = list_insert(id, lvl);
      KIND_REMOVE: res.status = list_remove(id);
      KIND_CHANGE: begin
        res.status = list_remove(id);
        if (res.status == ST_OK) res.status = list_insert(id, lvl);
      end
      default: begin
        if (int'(pos) < list_count) begin
          res.status      = ST_OK;
          res.entry_id    = list_ids[pos];
          res.entry_level = list_levels[pos];
        end else begin
          res.status = ST_INVALID;
        end
      end
    endcase
    res.entry_count = list_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic signed [LEVEL_W-1:0] lvl,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 12) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, pos, lvl, id};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_op(kind, id, lvl, pos));
  endtask

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d, data %h", out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[15:0] !== want.entry_id) begin
          $error("entry_id: expected %0d, got %0d", want.entry_id, out_tdata[15:0]);
          mismatch_count++;
        end
        if (out_tdata[31:16] !== want.entry_level) begin
          $error("entry_level: expected %0d, got %0d", want.entry_level,
                 $signed(out_tdata[31:16]));
          mismatch_count++;
        end
        if (out_tdata[38:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_tdata[38:32]);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 60 && list_count > 0) return list_ids[$urandom_range(list_count - 1)];
    if (r < 85) return ID_W'($urandom_range(96, 1));
    if (r < 97) return ID_W'($urandom_range(65535));
    return '0;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 40) return LEVEL_W'($urandom_range(6) - 3);
    if (r < 85) return LEVEL_W'($urandom_range(65535));
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (list_count > 0 && $urandom_range(99) < 80)
      return POS_W'($urandom_range(list_count - 1));
    return POS_W'($urandom_range(63));
  endfunction

  task automatic test_empty_list();
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd0);
    send_item(KIND_REMOVE, 16'd7, 16'sd0, 6'd0);
    send_item(KIND_CHANGE, 16'd7, 16'sd5, 6'd0);
  endtask

  task automatic test_zero_id();
    send_item(KIND_INSERT, 16'd0, 16'sd0, 6'd0);
    send_item(KIND_REMOVE, 16'd0, 16'sd0, 6'd0);
    send_item(KIND_CHANGE, 16'd0, 16'sd1, 6'd0);
  endtask

  task automatic test_order_and_ties();
    send_item(KIND_INSERT, 16'hffff, 16'sh7fff, 6'd0);
    send_item(KIND_INSERT, 16'd1, 16'sh8000, 6'd0);
    send_item(KIND_INSERT, 16'd2, 16'sd0, 6'd0);
    send_item(KIND_INSERT, 16'd3, 16'sd0, 6'd0);
    send_item(KIND_INSERT, 16'd2, 16'sd5, 6'd0);
    for (int p = 0; p < 5; p++) send_item(KIND_READ, 16'd0, 16'sd0, POS_W'(p));
    send_item(KIND_READ, 16'hffff, -16'sd1, 6'd63);
    send_item(KIND_CHANGE, 16'd1, 16'sd0, 6'd0);
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd2);
    send_item(KIND_REMOVE, 16'd3, 16'sd0, 6'd0);
    send_item(KIND_REMOVE, 16'd3, 16'sd0, 6'd0);
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd1);
  endtask

  task automatic test_fill_to_capacity();
    while (list_count < CAPACITY)
      send_item(KIND_INSERT, ID_W'($urandom_range(65535, 1)), pick_level(), 6'd0);
    send_item(KIND_INSERT, ID_W'($urandom_range(65535, 1)), pick_level(), 6'd0);
    send_item(KIND_INSERT, list_ids[5], 16'sd0, 6'd0);
    send_item(KIND_CHANGE, list_ids[0], 16'sh7fff, 6'd0);
    send_item(KIND_CHANGE, list_ids[CAPACITY-1], 16'sh8000, 6'd0);
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd63);
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd0);
    while (list_count > 0)
      send_item(KIND_REMOVE, list_ids[$urandom_range(list_count - 1)], 16'sd0, 6'd0);
    send_item(KIND_READ, 16'd0, 16'sd0, 6'd0);
  endtask

  task automatic test_random_mix(input int n_items);
    int r;
    int grow;
    logic [KIND_W-1:0] kind;
    for (int i = 0; i < n_items; i++) begin
      calm = (i >= n_items / 3) && (i < n_items / 3 + 200);
      grow = ((i / 150) % 2 == 0) ? 1 : 0;
      r = $urandom_range(99);
      if (r < (grow ? 50 : 15))      kind = KIND_INSERT;
      else if (r < 65)               kind = KIND_REMOVE;
      else if (r < 78)               kind = KIND_CHANGE;
      else                           kind = KIND_READ;
      send_item(kind, pick_id(), pick_level(), pick_position());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = KIND_INSERT;
    out_tready     = 1'b0;
    list_count     = 0;
    mismatch_count = 0;
    calm           = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_zero_id();
    test_order_and_ties();
    test_fill_to_capacity();
    test_random_mix(940);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_sorted_priority_list: clean");
    end else begin
      $display("tb_sorted_priority_list: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_sorted_priority_list: errors");
    $finish;
  end

endmodule

/* filelist.f */
src/spl_pkg.sv
src/spl_cell.sv
src/sorted_priority_list.sv
bench/tb_sorted_priority_list.sv
